// ===== design/gct_pkg.sv =====
// Package for the generation cancel table: request/response beats, op codes,
// and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gct_pkg;

  localparam int unsigned FIELD_W      = 64;
  localparam int unsigned GEN_W        = 64;
  localparam int unsigned SLOTS_DEF    = 32;
  localparam int unsigned KEY_BITS_DEF = 64;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_QUERY  = 2'd2
  } gct_op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] token;
  } gct_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] token_out;
    logic               cancelled;
    logic               evicted;
  } gct_rsp_t;

endpackage

`default_nettype wire

// ===== design/gct_gen_adv.sv =====
// Generation advance: increment, wrapping from all ones to 1 so zero never appears.
// Depends on gct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gct_gen_adv (
  input  wire logic [gct_pkg::GEN_W-1:0] gen_i,
  output logic      [gct_pkg::GEN_W-1:0] gen_o
);
  import gct_pkg::*;

  logic [GEN_W-1:0] inc;

  assign inc   = gen_i + GEN_W'(1);
  assign gen_o = (inc == '0) ? GEN_W'(1) : inc;

endmodule

`default_nettype wire

// ===== design/generation_cancel_table.sv =====
// An item with a nonzero key and a valid op is scanned linearly, one slot read per
// cycle from the slot RAM, until a hit or the last slot, then goes through one
// read-modify-write state before done_o. Empty key or op 3: done_o the next cycle.
// One item at a time; for a scanned item busy is high from accept until the
// result beat; empty key and op 3 never raise busy.
// Reset clears the used bits and control state at once; no clearing pass.
// The receiver cannot stall: done_o marks the result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module generation_cancel_table #(
  parameter int unsigned SLOTS    = gct_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = gct_pkg::KEY_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire gct_pkg::gct_req_t req_i,
  output logic                   done_o,
  output gct_pkg::gct_rsp_t      rsp_o
);
  import gct_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned ENT_W = KEY_BITS + GEN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MOD  = 3'b100
  } gct_state_e;

  gct_state_e state_q, state_d;

  logic [1:0]          op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [FIELD_W-1:0]  tok_q;

  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q, free_vld_q;
  logic [IDX_W-1:0] slot_q, free_idx_q;
  logic [GEN_W-1:0] ent_gen_q;
  logic             ent_flag_q;
  logic [SLOTS-1:0] used_q;

  logic [ENT_W-1:0] slot_mem [SLOTS];
  logic [ENT_W-1:0] mem_rd_q;

  logic                done_q;
  gct_rsp_t            rsp_q;

  logic                accept, trivial;
  logic [KEY_BITS-1:0] key_in, rd_key;
  logic [GEN_W-1:0]    rd_gen, base_gen, adv_gen;
  logic                rd_flag;
  logic                cmp_hit, cmp_last, cmp_free, issue;
  logic [IDX_W-1:0]    rd_addr, wr_slot;
  logic                mem_we, new_flag, q_canc, ev;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign key_in  = req_i.key[KEY_BITS-1:0];
  assign trivial = (key_in == '0) || !((req_i.op == OP_BEGIN) || (req_i.op == OP_CANCEL)
                                       || (req_i.op == OP_QUERY));

  assign rd_key  = mem_rd_q[ENT_W-1 -: KEY_BITS];
  assign rd_gen  = mem_rd_q[GEN_W:1];
  assign rd_flag = mem_rd_q[0];

  // compare stage sees the beat read in the previous cycle
  assign cmp_hit  = cmp_vld_q && used_q[cmp_idx_q] && (rd_key == key_q);
  assign cmp_last = cmp_vld_q && (cmp_idx_q == IDX_W'(SLOTS - 1));
  assign cmp_free = cmp_vld_q && !used_q[cmp_idx_q] && !free_vld_q;
  assign issue    = (state_q == ST_SCAN) && !cmp_hit && (scan_cnt_q < CNT_W'(SLOTS));
  assign rd_addr  = scan_cnt_q[IDX_W-1:0];

  // modify stage: a begin or cancel miss claims first free slot, else evicts slot 0
  assign base_gen = hit_q ? ent_gen_q : '0;
  assign wr_slot  = hit_q ? slot_q : (free_vld_q ? free_idx_q : '0);
  assign new_flag = (op_q == OP_CANCEL);
  assign mem_we   = (state_q == ST_MOD) && (op_q != OP_QUERY);
  assign q_canc   = hit_q && ((ent_gen_q != tok_q) || ent_flag_q);
  assign ev       = !hit_q && !free_vld_q;

  gct_gen_adv u_adv (
    .gen_i (base_gen),
    .gen_o (adv_gen)
  );

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = issue;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !trivial) begin
          state_d    = ST_SCAN;
          scan_cnt_d = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
        if (cmp_hit || cmp_last) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_vld_q <= 1'b0;
      used_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      done_q     <= (accept && trivial) || (state_q == ST_MOD);
      if (accept) begin
        hit_q      <= 1'b0;
        free_vld_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (cmp_hit) hit_q <= 1'b1;
        if (cmp_free) free_vld_q <= 1'b1;
      end
      if (mem_we) used_q[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= key_in;
      tok_q <= req_i.token;
    end
    if (issue) cmp_idx_q <= rd_addr;
    if (cmp_hit) begin
      slot_q     <= cmp_idx_q;
      ent_gen_q  <= rd_gen;
      ent_flag_q <= rd_flag;
    end
    if (cmp_free) free_idx_q <= cmp_idx_q;
    if (accept && trivial) begin
      rsp_q <= '0;
    end else if (state_q == ST_MOD) begin
      rsp_q.token_out <= (op_q == OP_BEGIN) ? adv_gen : '0;
      rsp_q.cancelled <= (op_q == OP_QUERY) && q_canc;
      rsp_q.evicted   <= (op_q != OP_QUERY) && ev;
    end
  end

  // slot RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[wr_slot] <= {key_q, adv_gen, new_flag};
    if (issue) mem_rd_q <= slot_mem[rd_addr];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_mod_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |=> (done_o && (state_q == ST_IDLE)))
    else $error("modify cycle did not produce a result beat");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_cnt_q <= CNT_W'(SLOTS)))
    else $error("scan ran past the last slot");

  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.cancelled && (rsp_o.evicted || (rsp_o.token_out != '0))))
    else $error("query result mixed with begin/cancel result");
`endif

endmodule

`default_nettype wire
